FILE: rtl/core/buddy_page_allocator_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the buddy page allocator
// Each macro binds to the clk and rst_n of the module that uses it.
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define BPA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the following cycle.
`define BPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BPA_ASSERT_SAME(label, ante, cons)
`define BPA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/bpa_pkg.sv
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Shared field widths, command and status codes, and the sequencer states.
// ---------------------------------------------------------------------------
package bpa_pkg;

  localparam int DEF_NUM_PAGES = 1024;
  localparam int DEF_MAX_ORDER = 11;

  localparam int CMD_W    = 2;
  localparam int ORDER_W  = 4;
  localparam int PAGE_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_ORDER = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_BLOCK  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_IGNORED   = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_SPLIT,
    S_ALLOC_MW,
    S_FREE_CHK,
    S_FREE_LOOP,
    S_FREE_BUD,
    S_FREE_MERGED,
    S_FREE_END,
    S_INIT_FILL,
    S_INIT_NEXT,
    S_U_RD,
    S_U_P,
    S_U_PW,
    S_U_N,
    S_U_NW,
    S_U_FIN,
    S_P_RD,
    S_P_W,
    S_P_HR,
    S_P_HW,
    S_P_FIN,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/buddy_page_allocator_top.sv
// ---------------------------------------------------------------------------
// Buddy page allocator
// Allocates and frees power-of-two blocks of page indices from per-order
// doubly linked free lists kept in a single page memory. Commands are handled
// one at a time by a sequencer that reads, modifies and writes back one page
// entry per step; the memory's registered read paces every step.
// An allocate scans the orders from the requested one upward, unlinks the
// block it finds and splits it down to the requested order, pushing each
// upper half; a free unlinks each free buddy it merges with, then pushes
// the result. An init sweeps all NUM_PAGES entries, one per cycle, then
// frees each pool page in turn.
// A result beat is held in an output register, so a new command beat is
// taken while the last result still waits. Before the first init the pool
// is empty.
// ---------------------------------------------------------------------------
`include "buddy_page_allocator_top_macros.svh"

module buddy_page_allocator_top #(
  parameter int NUM_PAGES = bpa_pkg::DEF_NUM_PAGES,
  parameter int MAX_ORDER = bpa_pkg::DEF_MAX_ORDER
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bpa_pkg::CMD_W-1:0]      in_command,
  input  logic [bpa_pkg::ORDER_W-1:0]    in_req_order,
  input  logic [bpa_pkg::PAGE_W-1:0]     in_page_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bpa_pkg::STATUS_W-1:0]   out_status,
  output logic [bpa_pkg::PAGE_W-1:0]     out_block_page,
  output logic [bpa_pkg::ORDER_W-1:0]    out_block_order,
  output logic [bpa_pkg::COUNT_W-1:0]    out_free_pages,
  input  logic                           cfg_we,
  input  logic [bpa_pkg::COUNT_W-1:0]    cfg_wdata
);
  import bpa_pkg::*;

  localparam int PIW = $clog2(NUM_PAGES);
  localparam int LW  = PIW + 1;
  localparam int CW  = $clog2(NUM_PAGES + 1);
  localparam int BW  = (LW > MAX_ORDER) ? LW : MAX_ORDER;
  localparam int OIW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam logic [LW-1:0]      NUL     = LW'(NUM_PAGES);
  localparam logic [ORDER_W-1:0] TOP_ORD = ORDER_W'(MAX_ORDER - 1);

  typedef struct packed {
    logic               used;
    logic [ORDER_W-1:0] order;
    logic [LW-1:0]      next;
    logic [LW-1:0]      prev;
  } ent_t;

  // Page memory.
  ent_t           mem [NUM_PAGES];
  ent_t           q;
  logic           mem_re, mem_we;
  logic [PIW-1:0] mem_raddr, mem_waddr;
  ent_t           mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      q <= mem[mem_raddr];
    end
  end

  // List heads and counts.
  logic [LW-1:0] head_r [MAX_ORDER];
  logic [CW-1:0] cnt_r  [MAX_ORDER];
  logic [CW-1:0] total_r;
  logic           tbl_clr, head_we, cnt_inc, cnt_dec;
  logic [OIW-1:0] head_wi, cnt_wi;
  logic [LW-1:0]  head_wd;

  // Sequencer registers.
  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic               init_r, init_nxt;
  logic [ORDER_W-1:0] req_r, req_nxt, cur_ord_r, cur_ord_nxt, f_ord_r, f_ord_nxt;
  logic [ORDER_W-1:0] op_ord_r, op_ord_nxt;
  logic [PIW-1:0]     blk_r, blk_nxt, f_idx_r, f_idx_nxt, op_idx_r, op_idx_nxt;
  logic [LW-1:0]      lp_r, lp_nxt, ln_r, ln_nxt, ph_r, ph_nxt;
  logic [CW-1:0]      i_r, i_nxt, pool_r, pool_nxt;
  logic [COUNT_W-1:0] page_cnt_r;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [PIW-1:0]     res_page_r, res_page_nxt;
  logic [ORDER_W-1:0] res_ord_r, res_ord_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PAGE_W-1:0]   out_page_r;
  logic [ORDER_W-1:0]  out_ord_r;
  logic [COUNT_W-1:0]  out_free_r;

  // Shared decisions.
  logic          in_acc, bad_order, free_oob, scan_hit, scan_null, scan_last;
  logic          merge_try, bud_match, prev_ok, ln_ok, ph_ok;
  logic          split_more, up_ok, init_more, fill_last, out_free;
  logic [BW-1:0] bud, up;
  logic [ORDER_W-1:0] ord_dn;

  assign in_acc     = in_valid && (state_r == S_IDLE);
  assign bad_order  = {1'b0, in_req_order} >= 5'(MAX_ORDER);
  assign free_oob   = 32'(in_page_index) >= 32'(pool_r);
  assign scan_hit   = cnt_r[cur_ord_r[OIW-1:0]] != '0;
  assign scan_null  = head_r[cur_ord_r[OIW-1:0]] >= NUL;
  assign scan_last  = cur_ord_r == TOP_ORD;
  assign bud        = BW'(f_idx_r) ^ (BW'(1) << f_ord_r);
  assign merge_try  = (f_ord_r < TOP_ORD) && (32'(bud) < 32'(pool_r));
  assign bud_match  = !q.used && (q.order == f_ord_r);
  assign prev_ok    = q.prev < NUL;
  assign ln_ok      = ln_r < NUL;
  assign ph_ok      = ph_r < NUL;
  assign split_more = cur_ord_r > req_r;
  assign ord_dn     = cur_ord_r - ORDER_W'(1);
  assign up         = BW'(blk_r) + (BW'(1) << ord_dn);
  assign up_ok      = 32'(up) < NUM_PAGES;
  assign init_more  = i_r < pool_r;
  assign fill_last  = i_r == CW'(NUM_PAGES - 1);
  assign out_free   = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_ALLOC: state_nxt = bad_order ? S_DONE : S_ALLOC_SCAN;
            CMD_FREE:  state_nxt = free_oob ? S_DONE : S_FREE_CHK;
            CMD_INIT:  state_nxt = S_INIT_FILL;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_ALLOC_SCAN: begin
        if (scan_hit) begin
          state_nxt = scan_null ? S_DONE : S_U_RD;
        end else if (scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_ALLOC_SPLIT: begin
        if (!split_more) begin
          state_nxt = S_ALLOC_MW;
        end else if (up_ok) begin
          state_nxt = S_P_RD;
        end
      end
      S_ALLOC_MW:    state_nxt = S_DONE;
      S_FREE_CHK:    state_nxt = q.used ? S_FREE_LOOP : (init_r ? S_FREE_END : S_DONE);
      S_FREE_LOOP:   state_nxt = merge_try ? S_FREE_BUD : S_P_RD;
      S_FREE_BUD:    state_nxt = bud_match ? S_U_RD : S_P_RD;
      S_FREE_MERGED: state_nxt = S_FREE_LOOP;
      S_FREE_END:    state_nxt = init_r ? S_INIT_NEXT : S_DONE;
      S_INIT_FILL:   state_nxt = fill_last ? S_INIT_NEXT : S_INIT_FILL;
      S_INIT_NEXT:   state_nxt = init_more ? S_FREE_CHK : S_DONE;
      S_U_RD:        state_nxt = S_U_P;
      S_U_P:         state_nxt = prev_ok ? S_U_PW : S_U_N;
      S_U_PW:        state_nxt = S_U_N;
      S_U_N:         state_nxt = ln_ok ? S_U_NW : S_U_FIN;
      S_U_NW:        state_nxt = S_U_FIN;
      S_U_FIN:       state_nxt = ret_r;
      S_P_RD:        state_nxt = S_P_W;
      S_P_W:         state_nxt = ph_ok ? S_P_HR : S_P_FIN;
      S_P_HR:        state_nxt = S_P_HW;
      S_P_HW:        state_nxt = S_P_FIN;
      S_P_FIN:       state_nxt = ret_r;
      S_DONE:        state_nxt = out_free ? S_IDLE : S_DONE;
      default:       state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    ret_nxt = ret_r;  init_nxt = init_r;  req_nxt = req_r;  cur_ord_nxt = cur_ord_r;
    f_ord_nxt = f_ord_r;  op_ord_nxt = op_ord_r;  blk_nxt = blk_r;  f_idx_nxt = f_idx_r;
    op_idx_nxt = op_idx_r;  lp_nxt = lp_r;  ln_nxt = ln_r;  ph_nxt = ph_r;
    i_nxt = i_r;  pool_nxt = pool_r;
    res_status_nxt = res_status_r;  res_page_nxt = res_page_r;  res_ord_nxt = res_ord_r;
    mem_re = 1'b0;  mem_raddr = '0;  mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = q;
    tbl_clr = 1'b0;  head_we = 1'b0;  head_wi = '0;  head_wd = '0;
    cnt_inc = 1'b0;  cnt_dec = 1'b0;  cnt_wi = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_status_nxt = STAT_OK;
          res_page_nxt   = '0;
          res_ord_nxt    = '0;
          case (in_command)
            CMD_ALLOC: begin
              req_nxt     = in_req_order;
              cur_ord_nxt = in_req_order;
              if (bad_order) begin
                res_status_nxt = STAT_BAD_ORDER;
              end
            end
            CMD_FREE: begin
              f_idx_nxt = PIW'(in_page_index);
              if (free_oob) begin
                res_status_nxt = STAT_IGNORED;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = PIW'(in_page_index);
              end
            end
            CMD_INIT: begin
              tbl_clr  = 1'b1;
              init_nxt = 1'b1;
              i_nxt    = '0;
              pool_nxt = (32'(page_cnt_r) < NUM_PAGES) ? CW'(page_cnt_r) : CW'(NUM_PAGES);
            end
            default: begin
            end
          endcase
        end
      end
      S_ALLOC_SCAN: begin
        if (scan_hit) begin
          if (scan_null) begin
            res_status_nxt = STAT_NO_BLOCK;
          end else begin
            blk_nxt    = head_r[cur_ord_r[OIW-1:0]][PIW-1:0];
            op_idx_nxt = head_r[cur_ord_r[OIW-1:0]][PIW-1:0];
            op_ord_nxt = cur_ord_r;
            ret_nxt    = S_ALLOC_SPLIT;
          end
        end else if (scan_last) begin
          res_status_nxt = STAT_NO_BLOCK;
        end else begin
          cur_ord_nxt = cur_ord_r + ORDER_W'(1);
        end
      end
      S_ALLOC_SPLIT: begin
        if (split_more) begin
          cur_ord_nxt = ord_dn;
          op_idx_nxt  = up[PIW-1:0];
          op_ord_nxt  = ord_dn;
          ret_nxt     = S_ALLOC_SPLIT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = blk_r;
        end
      end
      S_ALLOC_MW: begin
        mem_we          = 1'b1;
        mem_waddr       = blk_r;
        mem_wdata.used  = 1'b1;
        mem_wdata.order = req_r;
        res_page_nxt    = blk_r;
        res_ord_nxt     = req_r;
      end
      S_FREE_CHK: begin
        if (q.used) begin
          mem_we         = 1'b1;
          mem_waddr      = f_idx_r;
          mem_wdata.used = 1'b0;
          f_ord_nxt      = (q.order > TOP_ORD) ? TOP_ORD : q.order;
        end else begin
          res_status_nxt = STAT_IGNORED;
        end
      end
      S_FREE_LOOP: begin
        if (merge_try) begin
          mem_re     = 1'b1;
          mem_raddr  = bud[PIW-1:0];
          op_idx_nxt = bud[PIW-1:0];
        end else begin
          op_idx_nxt = f_idx_r;
          op_ord_nxt = f_ord_r;
          ret_nxt    = S_FREE_END;
        end
      end
      S_FREE_BUD: begin
        op_ord_nxt = f_ord_r;
        if (bud_match) begin
          ret_nxt = S_FREE_MERGED;
        end else begin
          op_idx_nxt = f_idx_r;
          ret_nxt    = S_FREE_END;
        end
      end
      S_FREE_MERGED: begin
        if (op_idx_r < f_idx_r) begin
          f_idx_nxt = op_idx_r;
        end
        f_ord_nxt = f_ord_r + ORDER_W'(1);
      end
      S_FREE_END: begin
        if (init_r) begin
          i_nxt = i_r + CW'(1);
        end else begin
          res_page_nxt = f_idx_r;
          res_ord_nxt  = f_ord_r;
        end
      end
      S_INIT_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = i_r[PIW-1:0];
        mem_wdata = '{used: 1'b1, order: '0, next: '0, prev: '0};
        i_nxt     = fill_last ? '0 : i_r + CW'(1);
      end
      S_INIT_NEXT: begin
        if (init_more) begin
          f_idx_nxt = i_r[PIW-1:0];
          mem_re    = 1'b1;
          mem_raddr = i_r[PIW-1:0];
        end else begin
          init_nxt = 1'b0;
        end
      end
      S_U_RD: begin
        mem_re    = 1'b1;
        mem_raddr = op_idx_r;
      end
      S_U_P: begin
        lp_nxt = q.prev;
        ln_nxt = q.next;
        if (prev_ok) begin
          mem_re    = 1'b1;
          mem_raddr = q.prev[PIW-1:0];
        end else begin
          head_we = 1'b1;
          head_wi = op_ord_r[OIW-1:0];
          head_wd = q.next;
        end
      end
      S_U_PW: begin
        mem_we         = 1'b1;
        mem_waddr      = lp_r[PIW-1:0];
        mem_wdata.next = ln_r;
      end
      S_U_N: begin
        if (ln_ok) begin
          mem_re    = 1'b1;
          mem_raddr = ln_r[PIW-1:0];
        end
      end
      S_U_NW: begin
        mem_we         = 1'b1;
        mem_waddr      = ln_r[PIW-1:0];
        mem_wdata.prev = lp_r;
      end
      S_U_FIN: begin
        cnt_dec = 1'b1;
        cnt_wi  = op_ord_r[OIW-1:0];
      end
      S_P_RD: begin
        mem_re    = 1'b1;
        mem_raddr = op_idx_r;
        ph_nxt    = head_r[op_ord_r[OIW-1:0]];
      end
      S_P_W: begin
        mem_we          = 1'b1;
        mem_waddr       = op_idx_r;
        mem_wdata.order = op_ord_r;
        mem_wdata.next  = ph_r;
        mem_wdata.prev  = NUL;
      end
      S_P_HR: begin
        mem_re    = 1'b1;
        mem_raddr = ph_r[PIW-1:0];
      end
      S_P_HW: begin
        mem_we         = 1'b1;
        mem_waddr      = ph_r[PIW-1:0];
        mem_wdata.prev = LW'(op_idx_r);
      end
      S_P_FIN: begin
        head_we = 1'b1;
        head_wi = op_ord_r[OIW-1:0];
        head_wd = LW'(op_idx_r);
        cnt_inc = 1'b1;
        cnt_wi  = op_ord_r[OIW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        head_r[k] <= NUL;
        cnt_r[k]  <= '0;
      end
      total_r <= '0;
    end else if (tbl_clr) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        head_r[k] <= NUL;
        cnt_r[k]  <= '0;
      end
      total_r <= '0;
    end else begin
      if (head_we) begin
        head_r[head_wi] <= head_wd;
      end
      if (cnt_inc) begin
        cnt_r[cnt_wi] <= cnt_r[cnt_wi] + CW'(1);
        total_r       <= total_r + (CW'(1) << op_ord_r);
      end else if (cnt_dec) begin
        cnt_r[cnt_wi] <= cnt_r[cnt_wi] - CW'(1);
        total_r       <= total_r - (CW'(1) << op_ord_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      init_r      <= 1'b0;
      pool_r      <= '0;
      page_cnt_r  <= COUNT_W'(1024);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      init_r  <= init_nxt;
      pool_r  <= pool_nxt;
      if (cfg_we) begin
        page_cnt_r <= cfg_wdata;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    cur_ord_r    <= cur_ord_nxt;
    f_ord_r      <= f_ord_nxt;
    op_ord_r     <= op_ord_nxt;
    blk_r        <= blk_nxt;
    f_idx_r      <= f_idx_nxt;
    op_idx_r     <= op_idx_nxt;
    lp_r         <= lp_nxt;
    ln_r         <= ln_nxt;
    ph_r         <= ph_nxt;
    i_r          <= i_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_ord_r    <= res_ord_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_page_r   <= PAGE_W'(res_page_r);
      out_ord_r    <= res_ord_r;
      out_free_r   <= COUNT_W'(total_r);
    end
  end

  assign in_stall        = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_page  = out_page_r;
  assign out_block_order = out_ord_r;
  assign out_free_pages  = out_free_r;

  `BPA_ASSERT_SAME(a_total_in_pool, 1'b1, total_r <= pool_r)
  `BPA_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r != S_IDLE)
  `BPA_ASSERT_NEXT(a_done_holds, (state_r == S_DONE) && out_valid_r && out_stall, state_r == S_DONE)
  `BPA_ASSERT_SAME(a_one_mem_access, mem_we, !mem_re)

endmodule

FILE: test/buddy_page_allocator_top_test.sv
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Sends allocate, free and init commands with random gaps and output stalls.
// It configures the pool size in several phases. A scoreboard keeps its own
// copy of the free lists, predicts each result beat and compares it with the
// block's output.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int PAGES = DEF_NUM_PAGES;
  localparam int ORDERS = DEF_MAX_ORDER;
  localparam int NIL = PAGES;
  localparam int STALL_LIMIT = 60000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page;
    logic [ORDER_W-1:0]  order;
    logic [COUNT_W-1:0]  free_pages;
  } alloc_result_t;

  class alloc_scoreboard;
    bit   used [PAGES];
    int   blk_order [PAGES];
    int   nxt [PAGES];
    int   prv [PAGES];
    int   head [ORDERS];
    int   cnt [ORDERS];
    int   free_total;
    int   page_count = 1024;
    int   pool;
    int   errors;
    int   held [$];
    alloc_result_t pending [$];

    function new();
      foreach (head[i]) head[i] = NIL;
    endfunction

    function void push_block(int idx, int o);
      blk_order[idx] = o;
      prv[idx] = NIL;
      nxt[idx] = head[o];
      if (head[o] < PAGES) prv[head[o]] = idx;
      head[o] = idx;
      cnt[o]++;
      free_total += 1 << o;
    endfunction

    function void unlink_block(int idx, int o);
      if (prv[idx] < PAGES) nxt[prv[idx]] = nxt[idx];
      else head[o] = nxt[idx];
      if (nxt[idx] < PAGES) prv[nxt[idx]] = prv[idx];
      cnt[o]--;
      free_total -= 1 << o;
    endfunction

    function bit release_block(int idx, output int pg, output int od);
      int o;
      int b;
      if (idx >= pool || !used[idx]) return 0;
      used[idx] = 0;
      o = blk_order[idx];
      if (o >= ORDERS) o = ORDERS - 1;
      while (o + 1 < ORDERS) begin
        b = idx ^ (1 << o);
        if (b >= pool || used[b] || blk_order[b] != o) break;
        unlink_block(b, o);
        if (b < idx) idx = b;
        o++;
      end
      push_block(idx, o);
      pg = idx;
      od = o;
      return 1;
    endfunction

    function void note(logic [CMD_W-1:0] cmd, logic [ORDER_W-1:0] req,
                       logic [PAGE_W-1:0] idx);
      alloc_result_t r;
      int i;
      int blk;
      int pg;
      int od;
      r = '0;
      if (cmd == CMD_ALLOC) begin
        if (req >= ORDERS) begin
          r.status = STAT_BAD_ORDER;
        end else begin
          i = int'(req);
          while (i < ORDERS && cnt[i] == 0) i++;
          if (i >= ORDERS) begin
            r.status = STAT_NO_BLOCK;
          end else begin
            blk = head[i];
            unlink_block(blk, i);
            while (i > req) begin
              i--;
              push_block(blk + (1 << i), i);
            end
            blk_order[blk] = int'(req);
            used[blk] = 1;
            held.push_back(blk);
            r.page = PAGE_W'(blk);
            r.order = req;
          end
        end
      end else if (cmd == CMD_FREE) begin
        if (release_block(int'(idx), pg, od)) begin
          r.page = PAGE_W'(pg);
          r.order = ORDER_W'(od);
          foreach (held[k]) if (held[k] == idx) begin
            held.delete(k);
            break;
          end
        end else begin
          r.status = STAT_IGNORED;
        end
      end else if (cmd == CMD_INIT) begin
        foreach (head[k]) begin
          head[k] = NIL;
          cnt[k] = 0;
        end
        foreach (used[k]) begin
          used[k] = 1;
          blk_order[k] = 0;
        end
        free_total = 0;
        held.delete();
        pool = page_count < PAGES ? page_count : PAGES;
        for (int k = 0; k < pool; k++) void'(release_block(k, pg, od));
      end
      r.free_pages = COUNT_W'(free_total);
      pending.push_back(r);
    endfunction

    function void check(alloc_result_t got);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status != e.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, e.status, got.status);
        errors++;
      end
      if (got.page != e.page) begin
        $display("%0t: block_page expected %0d actual %0d", $realtime, e.page, got.page);
        errors++;
      end
      if (got.order != e.order) begin
        $display("%0t: block_order expected %0d actual %0d", $realtime, e.order, got.order);
        errors++;
      end
      if (got.free_pages != e.free_pages) begin
        $display("%0t: free_pages expected %0d actual %0d", $realtime, e.free_pages,
                 got.free_pages);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command = CMD_ALLOC;
  logic [ORDER_W-1:0]  in_req_order = '0;
  logic [PAGE_W-1:0]   in_page_index = '0;
  logic                out_valid;
  logic                out_stall = 0;
  logic [STATUS_W-1:0] out_status;
  logic [PAGE_W-1:0]   out_block_page;
  logic [ORDER_W-1:0]  out_block_order;
  logic [COUNT_W-1:0]  out_free_pages;
  logic                cfg_we = 0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;

  alloc_scoreboard sb = new();
  bit quiet;
  int idle_cycles;

  buddy_page_allocator_top DUT (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note(in_command, in_req_order, in_page_index);
      if (out_valid && !out_stall)
        sb.check({out_status, out_block_page, out_block_order, out_free_pages});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
    out_stall <= !quiet && $urandom_range(99) < 8;
  end

  task automatic send(logic [CMD_W-1:0] cmd, logic [ORDER_W-1:0] ord,
                      logic [PAGE_W-1:0] idx);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_req_order <= ord;
    in_page_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pool(logic [COUNT_W-1:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    sb.page_count = int'(v);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // One random command; frees mostly target blocks that are really held.
  task automatic random_beat();
    int r;
    logic [ORDER_W-1:0] ord;
    r = $urandom_range(99);
    ord = ($urandom_range(99) < 15) ? ORDER_W'($urandom_range(15))
                                    : ORDER_W'($urandom_range(4));
    if (r < 52) send(CMD_ALLOC, ord, PAGE_W'($urandom_range(1023)));
    else if (r < 85 && sb.held.size() != 0)
      send(CMD_FREE, ORDER_W'($urandom_range(15)),
           PAGE_W'(sb.held[$urandom_range(sb.held.size() - 1)]));
    else if (r < 95)
      send(CMD_FREE, ORDER_W'($urandom_range(15)), PAGE_W'($urandom_range(1023)));
    else if (r < 99)
      send(CMD_NOP, ORDER_W'($urandom_range(15)), PAGE_W'($urandom_range(1023)));
    else send(CMD_INIT, ord, PAGE_W'($urandom_range(1023)));
  endtask

  initial begin
    logic [COUNT_W-1:0] sizes [8];
    sizes = '{11'd1024, 11'd1, 11'd2047, 11'd600,
              11'd3, 11'd1000, 11'd37, 11'd257};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Before init the pool is empty.
    send(CMD_ALLOC, 4'd0, 10'd0);
    send(CMD_FREE, 4'd0, 10'd5);
    send(CMD_NOP, 4'hF, 10'h3FF);
    send(CMD_INIT, 4'd0, 10'd0);
    send(CMD_ALLOC, 4'd15, 10'd0);
    send(CMD_ALLOC, 4'd11, 10'd0);
    send(CMD_ALLOC, 4'd10, 10'd0);
    send(CMD_ALLOC, 4'd0, 10'd0);
    send(CMD_FREE, 4'd0, 10'd0);
    send(CMD_FREE, 4'd0, 10'd0);
    send(CMD_FREE, 4'd0, 10'd1023);
    send(CMD_ALLOC, 4'd3, 10'd0);
    send(CMD_ALLOC, 4'd3, 10'd0);
    send(CMD_FREE, 4'd0, 10'd8);
    send(CMD_FREE, 4'd0, 10'd0);
    set_pool(11'd5);
    send(CMD_INIT, 4'd0, 10'd0);
    send(CMD_FREE, 4'd0, 10'd5);
    send(CMD_ALLOC, 4'd2, 10'd0);
    send(CMD_ALLOC, 4'd2, 10'd0);
    send(CMD_ALLOC, 4'd0, 10'd0);

    foreach (sizes[p]) begin
      set_pool(sizes[p]);
      send(CMD_INIT, 4'd0, 10'd0);
      for (int n = 0; n < 200; n++) begin
        quiet = (p == 3);
        random_beat();
      end
    end
    quiet = 0;
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/buddy_page_allocator_top.sv
test/buddy_page_allocator_top_test.sv
